// ----- rtl/core/clrt_pkg.sv -----
package clrt_pkg;

    // id width of every node field and link entry
    localparam int ID_W = 20;

    // default table depth
    localparam int NODE_COUNT_DEF = 1048576;

    // command codes
    localparam logic [2:0] MODE_INS_AFTER  = 3'd0;
    localparam logic [2:0] MODE_INS_BEFORE = 3'd1;
    localparam logic [2:0] MODE_RM_AFTER   = 3'd2;
    localparam logic [2:0] MODE_RM_BEFORE  = 3'd3;
    localparam logic [2:0] MODE_APPEND     = 3'd4;

    typedef logic [ID_W-1:0] id_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_S,
        ST_RED_N,
        ST_RD_A,
        ST_CAP_A,
        ST_RED_A,
        ST_RD_B,
        ST_CAP_B,
        ST_RED_B,
        ST_WR_1,
        ST_WR_2,
        ST_WR_RM,
        ST_WR_SELF,
        ST_FIN
    } state_t;

endpackage

// ----- rtl/core/circular_linked_ring_table.sv -----
// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  tdata: mode, station_id, new_station
// m_        out  m_tvalid / m_tready  tdata: answer_station
//
// one command at a time: s_tready is high only while the sequencer is idle
// a command makes 1 to 3 id-to-slot reductions in the shared reduction unit,
// none for an unused code; a reduction maps the id straight onto a slot when
// NODE_COUNT is a power of two or above 2^19, and otherwise takes a reciprocal
// multiply, a multiply-subtract and a correction
// the single read port of each link table makes the two reads of a remove serial
// reset clears only control state; the link tables stay undefined until written
// a command with a result holds in its last state while the previous result
// still waits in the output register
module circular_linked_ring_table #(
    parameter int NODE_COUNT = clrt_pkg::NODE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[2:0], station_id[22:3], new_station[42:23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // answer_station[19:0]
);

    localparam int ADDR_W = $clog2(NODE_COUNT);

    // input transaction fields
    logic [2:0]    in_mode;
    clrt_pkg::id_t in_sid;
    clrt_pkg::id_t in_nid;
    logic          accept;

    assign in_mode = s_tdata[2:0];
    assign in_sid  = s_tdata[22:3];
    assign in_nid  = s_tdata[42:23];

    clrt_pkg::state_t state_reg, state_next;

    // command context
    logic          fwd_reg, fwd_next;         // read table is next_link
    logic          rm_reg, rm_next;           // remove command
    logic          first_reg, first_next;     // first append, self link
    logic          out_en_reg, out_en_next;   // command gives a result
    clrt_pkg::id_t base_reg, base_next;       // node acted on
    clrt_pkg::id_t new_reg, new_next;         // node inserted
    clrt_pkg::id_t a_reg, a_next;             // first neighbour read
    clrt_pkg::id_t b_reg, b_next;             // second neighbour read
    logic [ADDR_W-1:0] ss_reg, ss_next;
    logic [ADDR_W-1:0] sn_reg, sn_next;
    logic [ADDR_W-1:0] sa_reg, sa_next;
    logic [ADDR_W-1:0] sb_reg, sb_next;

    // ring building state
    logic          started_reg, started_next;
    clrt_pkg::id_t last_reg, last_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    clrt_pkg::id_t m_data_reg, m_data_next;

    // shared reduction unit
    logic              red_start;
    clrt_pkg::id_t     red_id;
    logic              red_done;
    logic [ADDR_W-1:0] red_slot;

    // link tables, seen as the read side (f) and the other side (g)
    logic              f_we, g_we;
    logic [ADDR_W-1:0] f_waddr, g_waddr;
    clrt_pkg::id_t     f_wdata, g_wdata;
    logic [ADDR_W-1:0] rd_addr;
    clrt_pkg::id_t     f_rdata;

    logic              nxt_we, prv_we;
    logic [ADDR_W-1:0] nxt_waddr, prv_waddr;
    clrt_pkg::id_t     nxt_wdata, prv_wdata;
    clrt_pkg::id_t     nxt_rdata, prv_rdata;

    logic can_load;

    assign s_tready = (state_reg == clrt_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_load = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clrt_pkg::ST_IDLE: begin
                if (accept && (in_mode <= clrt_pkg::MODE_APPEND)) begin
                    state_next = clrt_pkg::ST_RED_S;
                end
            end
            clrt_pkg::ST_RED_S: begin
                if (red_done) begin
                    if (first_reg) begin
                        state_next = clrt_pkg::ST_WR_SELF;
                    end else if (rm_reg) begin
                        state_next = clrt_pkg::ST_RD_A;
                    end else begin
                        state_next = clrt_pkg::ST_RED_N;
                    end
                end
            end
            clrt_pkg::ST_RED_N: begin
                if (red_done) begin
                    state_next = clrt_pkg::ST_RD_A;
                end
            end
            clrt_pkg::ST_RD_A:  state_next = clrt_pkg::ST_CAP_A;
            clrt_pkg::ST_CAP_A: state_next = clrt_pkg::ST_RED_A;
            clrt_pkg::ST_RED_A: begin
                if (red_done) begin
                    state_next = rm_reg ? clrt_pkg::ST_RD_B : clrt_pkg::ST_WR_1;
                end
            end
            clrt_pkg::ST_RD_B:  state_next = clrt_pkg::ST_CAP_B;
            clrt_pkg::ST_CAP_B: state_next = clrt_pkg::ST_RED_B;
            clrt_pkg::ST_RED_B: begin
                if (red_done) begin
                    state_next = clrt_pkg::ST_WR_RM;
                end
            end
            clrt_pkg::ST_WR_1:    state_next = clrt_pkg::ST_WR_2;
            clrt_pkg::ST_WR_2:    state_next = clrt_pkg::ST_FIN;
            clrt_pkg::ST_WR_RM:   state_next = clrt_pkg::ST_FIN;
            clrt_pkg::ST_WR_SELF: state_next = clrt_pkg::ST_FIN;
            clrt_pkg::ST_FIN: begin
                if (!out_en_reg || can_load) begin
                    state_next = clrt_pkg::ST_IDLE;
                end
            end
            default: state_next = clrt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: reduction starts, table reads and writes
    always_comb begin
        red_start = 1'b0;
        red_id    = base_next;
        f_we      = 1'b0;
        g_we      = 1'b0;
        f_waddr   = ss_reg;
        g_waddr   = ss_reg;
        f_wdata   = base_reg;
        g_wdata   = base_reg;
        rd_addr   = ss_reg;
        unique case (state_reg)
            clrt_pkg::ST_IDLE: begin
                red_start = accept && (in_mode <= clrt_pkg::MODE_APPEND);
                red_id    = base_next;
            end
            clrt_pkg::ST_RED_S: begin
                red_start = red_done && !first_reg && !rm_reg;
                red_id    = new_reg;
            end
            clrt_pkg::ST_RD_A: begin
                rd_addr = ss_reg;
            end
            clrt_pkg::ST_CAP_A, clrt_pkg::ST_CAP_B: begin
                red_start = 1'b1;
                red_id    = f_rdata;
            end
            clrt_pkg::ST_RD_B: begin
                rd_addr = sa_reg;
            end
            // new node takes both links
            clrt_pkg::ST_WR_1: begin
                f_we    = 1'b1;
                g_we    = 1'b1;
                f_waddr = sn_reg;
                f_wdata = a_reg;
                g_waddr = sn_reg;
                g_wdata = base_reg;
            end
            // old neighbours point at the new node
            clrt_pkg::ST_WR_2: begin
                f_we    = 1'b1;
                g_we    = 1'b1;
                f_waddr = ss_reg;
                f_wdata = new_reg;
                g_waddr = sa_reg;
                g_wdata = new_reg;
            end
            // bridge over the removed node
            clrt_pkg::ST_WR_RM: begin
                f_we    = 1'b1;
                g_we    = 1'b1;
                f_waddr = ss_reg;
                f_wdata = b_reg;
                g_waddr = sb_reg;
                g_wdata = base_reg;
            end
            clrt_pkg::ST_WR_SELF: begin
                f_we    = 1'b1;
                g_we    = 1'b1;
                f_waddr = ss_reg;
                f_wdata = base_reg;
                g_waddr = ss_reg;
                g_wdata = base_reg;
            end
            default: begin
                red_start = 1'b0;
            end
        endcase
    end

    // direction swap between read side and other side
    assign nxt_we    = fwd_reg ? f_we    : g_we;
    assign nxt_waddr = fwd_reg ? f_waddr : g_waddr;
    assign nxt_wdata = fwd_reg ? f_wdata : g_wdata;
    assign prv_we    = fwd_reg ? g_we    : f_we;
    assign prv_waddr = fwd_reg ? g_waddr : f_waddr;
    assign prv_wdata = fwd_reg ? g_wdata : f_wdata;
    assign f_rdata   = fwd_reg ? nxt_rdata : prv_rdata;

    // command context and captures
    always_comb begin
        fwd_next     = fwd_reg;
        rm_next      = rm_reg;
        first_next   = first_reg;
        out_en_next  = out_en_reg;
        base_next    = base_reg;
        new_next     = new_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        ss_next      = ss_reg;
        sn_next      = sn_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        started_next = started_reg;
        last_next    = last_reg;
        case (state_reg)
            clrt_pkg::ST_IDLE: begin
                // a later append is an insert after the last appended node
                base_next = ((in_mode == clrt_pkg::MODE_APPEND) && started_reg) ?
                            last_reg : in_sid;
                if (accept) begin
                    new_next    = (in_mode == clrt_pkg::MODE_APPEND) ? in_sid : in_nid;
                    fwd_next    = (in_mode == clrt_pkg::MODE_INS_AFTER) ||
                                  (in_mode == clrt_pkg::MODE_RM_AFTER) ||
                                  (in_mode == clrt_pkg::MODE_APPEND);
                    rm_next     = (in_mode == clrt_pkg::MODE_RM_AFTER) ||
                                  (in_mode == clrt_pkg::MODE_RM_BEFORE);
                    first_next  = (in_mode == clrt_pkg::MODE_APPEND) && !started_reg;
                    out_en_next = (in_mode != clrt_pkg::MODE_APPEND);
                    if (in_mode == clrt_pkg::MODE_APPEND) begin
                        started_next = 1'b1;
                        last_next    = in_sid;
                    end
                end
            end
            clrt_pkg::ST_RED_S: begin
                if (red_done) begin
                    ss_next = red_slot;
                end
            end
            clrt_pkg::ST_RED_N: begin
                if (red_done) begin
                    sn_next = red_slot;
                end
            end
            clrt_pkg::ST_CAP_A: a_next = f_rdata;
            clrt_pkg::ST_RED_A: begin
                if (red_done) begin
                    sa_next = red_slot;
                end
            end
            clrt_pkg::ST_CAP_B: b_next = f_rdata;
            clrt_pkg::ST_RED_B: begin
                if (red_done) begin
                    sb_next = red_slot;
                end
            end
            default: begin
                a_next = a_reg;
            end
        endcase
    end

    // result register, freed by the downstream transaction
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == clrt_pkg::ST_FIN) && out_en_reg && can_load) begin
            m_valid_next = 1'b1;
            m_data_next  = a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= clrt_pkg::ST_IDLE;
            started_reg <= 1'b0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
        fwd_reg    <= fwd_next;
        rm_reg     <= rm_next;
        first_reg  <= first_next;
        out_en_reg <= out_en_next;
        base_reg   <= base_next;
        new_reg    <= new_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        ss_reg     <= ss_next;
        sn_reg     <= sn_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

    // id to table slot
    clrt_slot #(
        .NODE_COUNT(NODE_COUNT)
    ) u_slot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (red_start),
        .id_in   (red_id),
        .done    (red_done),
        .slot    (red_slot)
    );

    clrt_ram #(
        .WIDTH(clrt_pkg::ID_W),
        .DEPTH(NODE_COUNT)
    ) u_next_link (
        .aclk    (aclk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_waddr),
        .wr_data (nxt_wdata),
        .rd_addr (rd_addr),
        .rd_data (nxt_rdata)
    );

    clrt_ram #(
        .WIDTH(clrt_pkg::ID_W),
        .DEPTH(NODE_COUNT)
    ) u_prev_link (
        .aclk    (aclk),
        .wr_en   (prv_we),
        .wr_addr (prv_waddr),
        .wr_data (prv_wdata),
        .rd_addr (rd_addr),
        .rd_data (prv_rdata)
    );

endmodule

// ----- rtl/core/clrt_ram.sv -----
module clrt_ram #(
    parameter int WIDTH = clrt_pkg::ID_W,
    parameter int DEPTH = clrt_pkg::NODE_COUNT_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/clrt_slot.sv -----
module clrt_slot #(
    parameter int NODE_COUNT = clrt_pkg::NODE_COUNT_DEF,
    localparam int ADDR_W = $clog2(NODE_COUNT)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  clrt_pkg::id_t     id_in,
    output logic              done,
    output logic [ADDR_W-1:0] slot
);

    localparam int ID_W = clrt_pkg::ID_W;
    // ids map straight onto the table, or through a mask
    localparam bit DIRECT = (ADDR_W >= ID_W) || ((NODE_COUNT & (NODE_COUNT - 1)) == 0);

    generate
        if (DIRECT) begin : g_direct
            logic              done_reg;
            logic [ADDR_W-1:0] slot_reg;
            logic [ADDR_W-1:0] slot_next;

            // zero extend or keep the low bits
            assign slot_next = ADDR_W'(id_in);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    slot_reg <= slot_next;
                end
            end

            assign done = done_reg;
            assign slot = slot_reg;
        end else begin : g_recip
            // quotient estimate from a scaled reciprocal, low by at most one,
            // then multiply-subtract and one correction, one stage per cycle
            localparam int SHIFT = ID_W + ADDR_W;
            localparam int MW    = ID_W + 2;
            localparam int PW    = ID_W + MW;
            localparam int QW    = PW - SHIFT;
            localparam logic [MW-1:0]   RECIP   = MW'((64'd1 << SHIFT) / 64'(NODE_COUNT));
            localparam logic [ID_W-1:0] MODULUS = ID_W'(NODE_COUNT);

            logic [ID_W-1:0] id_reg;
            logic [PW-1:0]   prod_reg, prod_next;
            logic [QW-1:0]   quot;
            logic [ID_W-1:0] back;
            logic [ID_W-1:0] rem_reg, rem_next;
            logic            mul_reg, sub_reg, fix_reg, done_reg;

            assign prod_next = PW'(id_reg) * PW'(RECIP);
            assign quot      = prod_reg[PW-1:SHIFT];
            assign back      = ID_W'(quot) * MODULUS;

            always_comb begin
                rem_next = rem_reg;
                if (sub_reg) begin
                    rem_next = id_reg - back;
                end else if (fix_reg && (rem_reg >= MODULUS)) begin
                    rem_next = rem_reg - MODULUS;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    mul_reg  <= 1'b0;
                    sub_reg  <= 1'b0;
                    fix_reg  <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    mul_reg  <= start;
                    sub_reg  <= mul_reg;
                    fix_reg  <= sub_reg;
                    done_reg <= fix_reg;
                end
                if (start) begin
                    id_reg <= id_in;
                end
                if (mul_reg) begin
                    prod_reg <= prod_next;
                end
                rem_reg <= rem_next;
            end

            assign done = done_reg;
            assign slot = rem_reg[ADDR_W-1:0];
        end
    endgenerate

endmodule
